[hw/rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, constants and a helper function of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int COORD_BITS   = 32;
   localparam int EDGE_BITS    = COORD_BITS + 1;
   localparam int EMAG_BITS    = COORD_BITS;
   localparam int PROD_BITS    = 2 * EMAG_BITS;
   localparam int CMAG_BITS    = PROD_BITS + 1;
   localparam int BLEN_BITS    = 7;
   localparam int MAG_BITS     = 30;
   localparam int SQ_BITS      = 2 * MAG_BITS;
   localparam int SUM_BITS     = SQ_BITS + 2;
   localparam int ROOT_BITS    = SUM_BITS + 1;
   localparam int LEN_BITS     = SUM_BITS / 2;
   localparam int SQRT_STEPS   = SUM_BITS / 2 + 1;
   localparam int SQRT_PER_STG = 2;
   localparam int SQRT_STAGES  = SQRT_STEPS / SQRT_PER_STG;
   localparam int Q_BITS       = 15;
   localparam int DIV_STAGES   = Q_BITS;
   localparam int NUM_BITS     = MAG_BITS + Q_BITS + 1;
   localparam int DEN_BITS     = LEN_BITS + 1;
   localparam int NORM_BITS    = 16;
   localparam int IDX_BITS     = 16;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
      logic [IDX_BITS-1:0]          index_a;
      logic [IDX_BITS-1:0]          index_b;
      logic [IDX_BITS-1:0]          index_c;
   } req_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] normal_x;
      logic signed [NORM_BITS-1:0] normal_y;
      logic signed [NORM_BITS-1:0] normal_z;
      logic [IDX_BITS-1:0]         out_index_a;
      logic [IDX_BITS-1:0]         out_index_b;
      logic [IDX_BITS-1:0]         out_index_c;
      logic                        degenerate;
   } rsp_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]  v;
      logic [ROOT_BITS-1:0] r;
   } sqrt_st_type;

   // one step of the digit-by-digit square root, test bit 4^k
   function automatic sqrt_st_type sqrt_step(sqrt_st_type st, int k);
      logic [SUM_BITS+1:0] b;
      logic [SUM_BITS+1:0] t;
      sqrt_st_type         o;
      b = (SUM_BITS+2)'(1) << (2 * k);
      t = (SUM_BITS+2)'(st.r) + b;
      if ((SUM_BITS+2)'(st.v) >= t) begin
         o.v = st.v - t[SUM_BITS-1:0];
         o.r = (st.r >> 1) + b[ROOT_BITS-1:0];
      end else begin
         o.v = st.v;
         o.r = st.r >> 1;
      end
      return o;
   endfunction

endpackage

[hw/rtl/triangle_face_normal.sv]
// Pipeline: 39 register stages.
// Throughput: one item per cycle unless rsp_ready stalls; the square root (two steps
// per stage) and the three restoring dividers (one quotient bit per stage) set the depth.
// A low rsp_ready with a waiting result freezes every stage together.
// Reset (synchronous) clears all valid bits; payload registers keep data.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Cross product of two triangle edges, scaled to a Q1.14 unit normal.
// ----------------------------------------------------------------------------
module triangle_face_normal #(
   parameter int INDEX_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tfn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output tfn_pkg::rsp_type rsp_data
);
   import tfn_pkg::*;

   localparam int IW = (INDEX_WIDTH < IDX_BITS) ? INDEX_WIDTH : IDX_BITS;

   typedef struct packed {
      logic [IW-1:0] ia;
      logic [IW-1:0] ib;
      logic [IW-1:0] ic;
   } idx_type;

   typedef struct packed {
      logic [2:0]                neg;
      logic                      degen;
      logic [2:0][MAG_BITS-1:0]  m;
      idx_type                   idx;
   } carry_type;

   logic rsp_valid_ff;
   logic en;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: edges
   logic signed [EDGE_BITS-1:0] e1_ff [3];
   logic signed [EDGE_BITS-1:0] e2_ff [3];
   idx_type                     idx1_ff;
   logic                        v1_ff;
   logic signed [COORD_BITS-1:0] pa [3];
   logic signed [COORD_BITS-1:0] pb [3];
   logic signed [COORD_BITS-1:0] pc [3];

   assign pa[0] = req_data.ax; assign pa[1] = req_data.ay; assign pa[2] = req_data.az;
   assign pb[0] = req_data.bx; assign pb[1] = req_data.by_coord; assign pb[2] = req_data.bz;
   assign pc[0] = req_data.cx; assign pc[1] = req_data.cy; assign pc[2] = req_data.cz;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EDGE_BITS'(pa[i]) - EDGE_BITS'(pb[i]);
            e2_ff[i] <= EDGE_BITS'(pb[i]) - EDGE_BITS'(pc[i]);
         end
         idx1_ff.ia <= req_data.index_a[IW-1:0];
         idx1_ff.ib <= req_data.index_b[IW-1:0];
         idx1_ff.ic <= req_data.index_c[IW-1:0];
      end
   end

   // stage 2: a pair of edge products per cross component, in sign-magnitude form
   logic [EMAG_BITS-1:0] m1 [3];
   logic [EMAG_BITS-1:0] m2 [3];
   logic [PROD_BITS-1:0] pp_ff [3];
   logic [PROD_BITS-1:0] pq_ff [3];
   logic [2:0]           pp_neg_ff;
   logic [2:0]           pq_neg_ff;
   idx_type              idx2_ff;
   logic                 v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1[i] = e1_ff[i][EDGE_BITS-1] ? EMAG_BITS'(-e1_ff[i]) : EMAG_BITS'(e1_ff[i]);
         m2[i] = e2_ff[i][EDGE_BITS-1] ? EMAG_BITS'(-e2_ff[i]) : EMAG_BITS'(e2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pp_ff[i]     <= m1[(i+1)%3] * m2[(i+2)%3];
            pq_ff[i]     <= m1[(i+2)%3] * m2[(i+1)%3];
            pp_neg_ff[i] <= e1_ff[(i+1)%3][EDGE_BITS-1] ^ e2_ff[(i+2)%3][EDGE_BITS-1];
            pq_neg_ff[i] <= e1_ff[(i+2)%3][EDGE_BITS-1] ^ e2_ff[(i+1)%3][EDGE_BITS-1];
         end
         idx2_ff <= idx1_ff;
      end
   end

   // stage 3: cross components, exact
   logic signed [PROD_BITS+2:0] cdiff [3];
   logic [CMAG_BITS-1:0]        cmag3_ff [3];
   logic [2:0]                  neg3_ff;
   idx_type                     idx3_ff;
   logic                        v3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cdiff[i] = (pp_neg_ff[i] ? -$signed((PROD_BITS+3)'(pp_ff[i]))
                                  :  $signed((PROD_BITS+3)'(pp_ff[i])))
                  - (pq_neg_ff[i] ? -$signed((PROD_BITS+3)'(pq_ff[i]))
                                  :  $signed((PROD_BITS+3)'(pq_ff[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg3_ff[i]  <= cdiff[i][PROD_BITS+2];
            cmag3_ff[i] <= cdiff[i][PROD_BITS+2] ? CMAG_BITS'(-cdiff[i])
                                                 : CMAG_BITS'(cdiff[i]);
         end
         idx3_ff <= idx2_ff;
      end
   end

   // stage 4: bit length of the largest magnitude, shift amount
   logic [CMAG_BITS-1:0] cor;
   logic [BLEN_BITS-1:0] blen;
   logic [CMAG_BITS-1:0] cmag4_ff [3];
   logic [BLEN_BITS-1:0] sh4_ff;
   logic [2:0]           neg4_ff;
   logic                 degen4_ff;
   idx_type              idx4_ff;
   logic                 v4_ff;

   always_comb begin
      cor  = cmag3_ff[0] | cmag3_ff[1] | cmag3_ff[2];
      blen = '0;
      for (int b = 0; b < CMAG_BITS; b++) begin
         if (cor[b]) blen = BLEN_BITS'(b + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmag4_ff  <= cmag3_ff;
         sh4_ff    <= (blen > BLEN_BITS'(MAG_BITS)) ? blen - BLEN_BITS'(MAG_BITS) : '0;
         neg4_ff   <= neg3_ff;
         degen4_ff <= (cor == '0);
         idx4_ff   <= idx3_ff;
      end
   end

   // stage 5: bring all magnitudes below 2^30
   carry_type c5_ff;
   logic      v5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c5_ff.m[i] <= MAG_BITS'(cmag4_ff[i] >> sh4_ff);
         end
         c5_ff.neg   <= neg4_ff;
         c5_ff.degen <= degen4_ff;
         c5_ff.idx   <= idx4_ff;
      end
   end

   // stage 6: squares
   logic [SQ_BITS-1:0] sq_ff [3];
   carry_type          c6_ff;
   logic               v6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= c5_ff.m[i] * c5_ff.m[i];
         end
         c6_ff <= c5_ff;
      end
   end

   // stage 7: sum of squares
   logic [SUM_BITS-1:0] sum_ff;
   carry_type           c7_ff;
   logic                v7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
         c7_ff  <= c6_ff;
      end
   end

   // square root, two result bits per stage
   sqrt_st_type sqs_ff [SQRT_STAGES];
   carry_type   sqc_ff [SQRT_STAGES];
   logic        sqv_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sqrt_st_type st_in;
      sqrt_st_type st_mid;
      carry_type   c_in;
      logic        v_in;
      if (g == 0) begin : g_first
         assign st_in.v = sum_ff;
         assign st_in.r = '0;
         assign c_in    = c7_ff;
         assign v_in    = v7_ff;
      end else begin : g_next
         assign st_in = sqs_ff[g-1];
         assign c_in  = sqc_ff[g-1];
         assign v_in  = sqv_ff[g-1];
      end
      assign st_mid = sqrt_step(st_in, SQRT_STEPS - 1 - SQRT_PER_STG * g);
      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[g] <= 1'b0;
         end else if (en) begin
            sqv_ff[g] <= v_in;
         end
         if (en) begin
            sqs_ff[g] <= sqrt_step(st_mid, SQRT_STEPS - 2 - SQRT_PER_STG * g);
            sqc_ff[g] <= c_in;
         end
      end
   end

   // restoring division, one quotient bit per stage in each lane
   logic [NUM_BITS-1:0]  drem_ff [DIV_STAGES][3];
   logic [Q_BITS-1:0]    dq_ff   [DIV_STAGES][3];
   logic [DEN_BITS-1:0]  dden_ff [DIV_STAGES];
   carry_type            dc_ff   [DIV_STAGES];
   logic                 dv_ff   [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [NUM_BITS-1:0] rem_in [3];
      logic [Q_BITS-1:0]   q_in   [3];
      logic [DEN_BITS-1:0] den_in;
      carry_type           c_in;
      logic                v_in;
      logic [NUM_BITS:0]   dsh;
      if (g == 0) begin : g_first
         logic [LEN_BITS-1:0] len;
         assign len    = sqs_ff[SQRT_STAGES-1].r[LEN_BITS-1:0];
         assign den_in = {len, 1'b0};
         assign c_in   = sqc_ff[SQRT_STAGES-1];
         assign v_in   = sqv_ff[SQRT_STAGES-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_in[i] = {1'b0, sqc_ff[SQRT_STAGES-1].m[i], {Q_BITS{1'b0}}}
                             + NUM_BITS'(len);
            assign q_in[i]   = '0;
         end
      end else begin : g_next
         assign den_in = dden_ff[g-1];
         assign c_in   = dc_ff[g-1];
         assign v_in   = dv_ff[g-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_in[i] = drem_ff[g-1][i];
            assign q_in[i]   = dq_ff[g-1][i];
         end
      end
      assign dsh = (NUM_BITS+1)'(den_in) << (Q_BITS - 1 - g);
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g] <= 1'b0;
         end else if (en) begin
            dv_ff[g] <= v_in;
         end
         if (en) begin
            dden_ff[g] <= den_in;
            dc_ff[g]   <= c_in;
            for (int i = 0; i < 3; i++) begin
               if ((NUM_BITS+1)'(rem_in[i]) >= dsh) begin
                  drem_ff[g][i] <= rem_in[i] - dsh[NUM_BITS-1:0];
                  dq_ff[g][i]   <= q_in[i] | (Q_BITS'(1) << (Q_BITS - 1 - g));
               end else begin
                  drem_ff[g][i] <= rem_in[i];
                  dq_ff[g][i]   <= q_in[i];
               end
            end
         end
      end
   end

   // output register: apply sign, zero the degenerate case
   rsp_type   rsp_ff;
   carry_type cl;
   logic signed [NORM_BITS-1:0] nrm [3];

   assign cl = dc_ff[DIV_STAGES-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i] = $signed(NORM_BITS'(dq_ff[DIV_STAGES-1][i]));
         if (cl.degen)      nrm[i] = '0;
         else if (cl.neg[i]) nrm[i] = -nrm[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         rsp_valid_ff <= dv_ff[DIV_STAGES-1];
      end
      if (en) begin
         rsp_ff.normal_x    <= nrm[0];
         rsp_ff.normal_y    <= nrm[1];
         rsp_ff.normal_z    <= nrm[2];
         rsp_ff.out_index_a <= IDX_BITS'(cl.idx.ia);
         rsp_ff.out_index_b <= IDX_BITS'(cl.idx.ib);
         rsp_ff.out_index_c <= IDX_BITS'(cl.idx.ic);
         rsp_ff.degenerate  <= cl.degen;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   localparam logic signed [NORM_BITS-1:0] ONE = NORM_BITS'(1 << (Q_BITS - 1));

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.degenerate |->
         rsp_ff.normal_x == '0 && rsp_ff.normal_y == '0 && rsp_ff.normal_z == '0)
      else $error("degenerate item with nonzero normal");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.degenerate |->
         rsp_ff.normal_x != '0 || rsp_ff.normal_y != '0 || rsp_ff.normal_z != '0)
      else $error("proper triangle with zero normal");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.normal_x <= ONE && rsp_ff.normal_x >= -ONE &&
                       rsp_ff.normal_y <= ONE && rsp_ff.normal_y >= -ONE &&
                       rsp_ff.normal_z <= ONE && rsp_ff.normal_z >= -ONE)
      else $error("normal component beyond unit range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !v1_ff)
      else $error("pipeline not empty after reset");

endmodule

[tb/tb_triangle_face_normal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal
// Streams triangles through the face normal pipeline and checks every normal
// and index against a bit-exact predictor, under idle, stall and back-pressure.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal;
   import tfn_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type face_q[$];
   rsp_type normal_q[$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   logic    hold_off = 1'b0;
   int      mismatches = 0;
   int      faces_sent = 0;
   int      normals_seen = 0;
   int      degenerate_seen = 0;

   triangle_face_normal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact cross product of (a-b) x (b-c), scaled to Q1.14 unit length
   function automatic rsp_type face_normal(req_type t);
      logic signed [33:0] e1[3];
      logic signed [33:0] e2[3];
      logic signed [69:0] cr[3];
      logic [69:0]        mag[3];
      logic [69:0]        mx;
      logic [63:0]        msh[3];
      logic [63:0]        sum, v, root, bitv, q;
      logic [15:0]        nrm[3];
      int                 blen, sh;
      rsp_type            r;
      e1[0] = t.ax - t.bx;        e2[0] = t.bx - t.cx;
      e1[1] = t.ay - t.by_coord;  e2[1] = t.by_coord - t.cy;
      e1[2] = t.az - t.bz;        e2[2] = t.bz - t.cz;
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      mx = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
         if (mag[i] > mx) mx = mag[i];
      end
      blen = 0;
      for (int i = 0; i < 70; i++)
         if (mx[i]) blen = i + 1;
      sh = blen > 30 ? blen - 30 : 0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         msh[i] = 64'(mag[i] >> sh);
         sum += msh[i] * msh[i];
      end
      v = sum;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = '0;
         if (mx != 0 && root != 0) q = (msh[i] * 32768 + root) / (2 * root);
         nrm[i] = cr[i] < 0 ? -q[15:0] : q[15:0];
      end
      r.normal_x    = nrm[0];
      r.normal_y    = nrm[1];
      r.normal_z    = nrm[2];
      r.out_index_a = t.index_a;
      r.out_index_b = t.index_b;
      r.out_index_c = t.index_c;
      r.degenerate  = (mx == 0);
      return r;
   endfunction

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed(16'($urandom)));
         2: return 32'($signed(8'($urandom)));
         default: return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   function automatic req_type rand_face();
      req_type t;
      int      mode;
      mode = $urandom_range(3, 0);
      t.ax = rand_coord(mode); t.ay = rand_coord(mode); t.az = rand_coord(mode);
      t.bx = rand_coord(mode); t.by_coord = rand_coord(mode); t.bz = rand_coord(mode);
      t.cx = rand_coord(mode); t.cy = rand_coord(mode); t.cz = rand_coord(mode);
      case ($urandom_range(9, 0))
         0: begin  // repeated vertex, no area
            t.cx = t.bx; t.cy = t.by_coord; t.cz = t.bz;
         end
         1: begin  // all three vertices coincide
            t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az;
            t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
         end
         default: ;
      endcase
      t.index_a = $urandom;
      t.index_b = $urandom;
      t.index_c = $urandom;
      return t;
   endfunction

   function automatic req_type make_face(logic [31:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz, logic [15:0] ia, ib, ic);
      req_type t;
      t.ax = ax; t.ay = ay; t.az = az;
      t.bx = bx; t.by_coord = by; t.bz = bz;
      t.cx = cx; t.cy = cy; t.cz = cz;
      t.index_a = ia; t.index_b = ib; t.index_c = ic;
      return t;
   endfunction

   task automatic add_face(req_type t);
      face_q = {face_q, t};
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: normal #%0d %s got %0h want %0h", $time, normals_seen, what, got, want);
   endtask

   // driver: advance to the next pending face once the current one is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            normal_q = {normal_q, face_normal(req_data)};
            faces_sent++;
         end
         if (!req_valid || req_ready) begin
            if (face_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= face_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (normal_q.size() == 0) begin
               report("unexpected item", 32'(rsp_data.degenerate), 0);
            end else begin
               rsp_type w;
               w = normal_q.pop_front();
               if (rsp_data.normal_x !== w.normal_x)
                  report("normal_x", 32'(rsp_data.normal_x), 32'(w.normal_x));
               if (rsp_data.normal_y !== w.normal_y)
                  report("normal_y", 32'(rsp_data.normal_y), 32'(w.normal_y));
               if (rsp_data.normal_z !== w.normal_z)
                  report("normal_z", 32'(rsp_data.normal_z), 32'(w.normal_z));
               if (rsp_data.out_index_a !== w.out_index_a)
                  report("out_index_a", 32'(rsp_data.out_index_a), 32'(w.out_index_a));
               if (rsp_data.out_index_b !== w.out_index_b)
                  report("out_index_b", 32'(rsp_data.out_index_b), 32'(w.out_index_b));
               if (rsp_data.out_index_c !== w.out_index_c)
                  report("out_index_c", 32'(rsp_data.out_index_c), 32'(w.out_index_c));
               if (rsp_data.degenerate !== w.degenerate)
                  report("degenerate", 32'(rsp_data.degenerate), 32'(w.degenerate));
               if (w.degenerate) degenerate_seen++;
            end
            normals_seen++;
         end
         rsp_ready <= !hold_off && $urandom_range(99, 0) >= stall_pct;
      end
   end

   task automatic drain();
      wait (face_q.size() == 0 && !req_valid && normal_q.size() == 0);
      @(posedge clock);
   endtask

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < n; i++) add_face(rand_face());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000));
      add_face(make_face(32'h0001_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0,
                         16'hffff, 16'hffff, 16'hffff));
      add_face(make_face(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
                         32'h0001_0000, 0, 16'h0001, 16'h8000, 16'h7fff));
      add_face(make_face(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000,
                         16'h1234, 16'h5678, 16'h9abc));
      add_face(make_face(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         16'hffff, 16'h0000, 16'hffff));
      add_face(make_face(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         16'h0000, 16'hffff, 16'h0000));
      add_face(make_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         16'h00ff, 16'hff00, 16'h0f0f));
      add_face(make_face(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         0, 0, 0, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001,
                         16'd1, 16'd2, 16'd3));
      add_face(make_face(1, 0, 0, 0, 0, 0, 0, 1, 0, 16'd4, 16'd5, 16'd6));
      add_face(make_face(1, 0, 0, 0, 0, 0, 0, 0, 1, 16'd7, 16'd8, 16'd9));
      add_face(make_face(32'hffff_ffff, 1, 0, 0, 0, 0, 1, 1, 1, 16'd10, 16'd11, 16'd12));
      add_face(make_face(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 0,
                         32'h0004_0000, 32'h0004_0000, 0, 16'd13, 16'd14, 16'd15));
      add_face(make_face(3, 0, 0, 0, 0, 0, 0, 4, 0, 16'd16, 16'd17, 16'd18));
      add_face(make_face(32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
                         0, 0, 0, 32'h0000_1000, 32'hffff_f000, 32'h0000_0800,
                         16'd19, 16'd20, 16'd21));
      drain();

      run_phase(400, 0, 0);
      run_phase(300, 77, 0);
      run_phase(300, 0, 77);
      run_phase(300, 21, 21);

      // hold the result side off so the pipeline fills and stalls its input
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int i = 0; i < 200; i++) add_face(rand_face());
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
      drain();

      repeat (60) @(posedge clock);
      $display("Covered %0d faces, %0d normals checked, %0d degenerate.",
               faces_sent, normals_seen, degenerate_seen);
      $display("Phases: free flow, sender idle, receiver stall, mixed, long hold-off.");
      if (mismatches == 0 && normal_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d normals outstanding", normal_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hw/rtl/tfn_pkg.sv
hw/rtl/triangle_face_normal.sv
tb/tb_triangle_face_normal.sv
